FILE: sv/tmq_pkg.sv
// tmq_pkg: shared constants and codes of the ordered timer queue
// no dependencies
package tmq_pkg;

  localparam int unsigned TimerSlotsDef = 16;
  localparam int unsigned GenBitsDef    = 8;
  localparam int unsigned MaxResults    = 16;
  localparam int unsigned TimeW         = 62;
  localparam int unsigned PeriodW       = 40;
  localparam int unsigned DelayW        = 16;
  localparam logic [DelayW-1:0] MinDelayRst = 16'd100;

  localparam logic [1:0] KindAdd    = 2'd0;
  localparam logic [1:0] KindCancel = 2'd1;
  localparam logic [1:0] KindTick   = 2'd2;
  localparam logic [1:0] KindUnused = 2'd3;

  localparam logic [1:0] StatOk      = 2'd0;
  localparam logic [1:0] StatFull    = 2'd1;
  localparam logic [1:0] StatMiss    = 2'd2;
  localparam logic [1:0] StatNotDue  = 2'd3;

  localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};

endpackage

FILE: sv/timer_queue_manager_top.sv
// timer_queue_manager_top: table of timer slots run by a scan sequencer
// throughput: one item at a time; every scan passes the slots one per cycle
// through the deadline ram and the shared compare unit
// reset: no timer armed, all generations zero, min arm delay 100; no clearing pass
module timer_queue_manager_top import tmq_pkg::*; #(
  parameter int unsigned TimerSlots = TimerSlotsDef,
  parameter int unsigned GenBits    = GenBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                min_arm_delay_us_we_i,
  input  logic [DelayW-1:0]   min_arm_delay_us_i,
  // input channel
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          kind_i,
  input  logic [TimeW-1:0]    now_us_i,
  input  logic [TimeW-1:0]    deadline_us_i,
  input  logic [PeriodW-1:0]  interval_us_i,
  input  logic [3:0]          handle_slot_i,
  input  logic [7:0]          handle_generation_i,
  // output channel
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          status_o,
  output logic [3:0]          slot_o,
  output logic [7:0]          generation_o,
  output logic                fired_o,
  output logic                head_moved_o,
  output logic                has_deadline_o,
  output logic [TimeW-1:0]    next_deadline_us_o,
  output logic [TimeW-1:0]    arm_delay_us_o,
  output logic                last_o
);
  localparam int unsigned SW  = (TimerSlots > 1) ? $clog2(TimerSlots) : 1;
  localparam int unsigned CW  = $clog2(TimerSlots + 1);
  localparam int unsigned HW  = (SW > 4) ? SW : 4;
  localparam int unsigned GW2 = (GenBits > 8) ? GenBits : 8;
  localparam int unsigned FW  = $clog2(MaxResults + 1);
  localparam int unsigned LW  = $clog2(MaxResults);

  typedef enum logic [2:0] {
    StIdle, StScan, StTupd, StAddw, StFin, StEmit
  } state_e;

  typedef enum logic [1:0] {
    ModePreAdd, ModeTick, ModeFinal
  } mode_e;

  state_e state_q;
  mode_e  mode_q;

  // configuration register
  logic [DelayW-1:0] min_q;

  // slot state in flops
  logic [TimerSlots-1:0] armed_q;
  logic [TimerSlots-1:0] picked_q;
  logic [GenBits-1:0]    gen_q [TimerSlots];

  // latched item
  logic [1:0]         kind_q;
  logic [TimeW-1:0]   now_q;
  logic [TimeW-1:0]   dl_q;
  logic [PeriodW-1:0] per_q;
  logic [SW-1:0]      free_q;

  // result fields
  logic [1:0]         rstat_q;
  logic [3:0]         rslot_q;
  logic [7:0]         rgen_q;
  logic               rchg_q;
  logic               rhas_q;
  logic [TimeW-1:0]   rnext_q;
  logic [TimeW-1:0]   rdelay_q;

  // fired list of a tick
  logic [SW-1:0]      lslot_q [MaxResults];
  logic [7:0]         lgen_q  [MaxResults];
  logic [FW-1:0]      nfired_q;
  logic [FW-1:0]      emit_q;

  // scan control
  logic [CW-1:0]      cnt_q;
  logic               v1_q;
  logic [SW-1:0]      s1_q;
  logic               scan_start;
  logic               scan_done;

  // rams
  logic               dl_we;
  logic [SW-1:0]      dl_waddr;
  logic [TimeW-1:0]   dl_wdata;
  logic [TimeW-1:0]   dl_rdata;
  logic [PeriodW-1:0] per_rdata;

  // compare unit
  logic               cand_valid;
  logic               found;
  logic [TimeW-1:0]   best_dl;
  logic [SW-1:0]      best_slot;

  // free slot search and cancel check on the raw inputs
  logic               any_free;
  logic [SW-1:0]      free_idx;
  logic [HW-1:0]      hs_w;
  logic               cancel_hit;
  logic [TimeW:0]     rearm_sum;
  logic [TimeW-1:0]   rearm_dl;
  logic [TimeW-1:0]   diff;
  logic [FW-1:0]      n_res;

  always_comb begin
    any_free = 1'b0;
    free_idx = '0;
    for (int i = TimerSlots - 1; i >= 0; i--) begin
      if (!armed_q[i]) begin
        any_free = 1'b1;
        free_idx = SW'(i);
      end
    end
  end

  // one extra bit so the slot count itself fits in the compare
  assign hs_w       = HW'(handle_slot_i);
  assign cancel_hit = ({1'b0, hs_w} < (HW + 1)'(TimerSlots)) && armed_q[hs_w[SW-1:0]]
                      && (GW2'(gen_q[hs_w[SW-1:0]]) == GW2'(handle_generation_i));

  // re-arm at now plus period, saturated to the time width
  assign rearm_sum = {1'b0, now_q} + (TimeW + 1)'(per_rdata);
  assign rearm_dl  = rearm_sum[TimeW] ? TimeMax : rearm_sum[TimeW-1:0];
  assign diff      = (best_dl > now_q) ? best_dl - now_q : '0;

  assign n_res = (kind_q == KindTick && nfired_q != '0) ? nfired_q : FW'(1);

  assign scan_done  = (state_q == StScan) && (cnt_q == CW'(TimerSlots)) && !v1_q;
  assign cand_valid = (state_q == StScan) && v1_q && armed_q[s1_q]
                      && (mode_q != ModeTick || (!picked_q[s1_q] && dl_rdata <= now_q));

  // deadline ram writes: add at the free slot, re-arm at the picked slot
  always_comb begin
    dl_we    = 1'b0;
    dl_waddr = free_q;
    dl_wdata = dl_q;
    if (state_q == StAddw) begin
      dl_we = 1'b1;
    end else if (state_q == StTupd && per_rdata != '0) begin
      dl_we    = 1'b1;
      dl_waddr = best_slot;
      dl_wdata = rearm_dl;
    end
  end

  tmq_ram #(.Width(TimeW), .Depth(TimerSlots)) u_dl_ram (
    .clk_i   (clk_i),
    .we_i    (dl_we),
    .waddr_i (dl_waddr),
    .wdata_i (dl_wdata),
    .raddr_i (cnt_q[SW-1:0]),
    .rdata_o (dl_rdata)
  );

  tmq_ram #(.Width(PeriodW), .Depth(TimerSlots)) u_per_ram (
    .clk_i   (clk_i),
    .we_i    (state_q == StAddw),
    .waddr_i (free_q),
    .wdata_i (per_q),
    .raddr_i (best_slot),
    .rdata_o (per_rdata)
  );

  tmq_min_unit #(.SlotW(SW)) u_min (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clear_i      (scan_start),
    .cand_valid_i (cand_valid),
    .cand_dl_i    (dl_rdata),
    .cand_slot_i  (s1_q),
    .found_o      (found),
    .best_dl_o    (best_dl),
    .best_slot_o  (best_slot)
  );

  assign in_ready_o = (state_q == StIdle);

  // a new scan starts whenever the sequencer enters the scan state
  always_comb begin
    scan_start = 1'b0;
    case (state_q)
      StIdle: scan_start = in_valid_i;
      StScan: scan_start = scan_done && (mode_q != ModeFinal);
      StTupd, StAddw: scan_start = 1'b1;
      default: scan_start = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= MinDelayRst;
    end else if (min_arm_delay_us_we_i) begin
      min_q <= min_arm_delay_us_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      mode_q      <= ModeFinal;
      armed_q     <= '0;
      picked_q    <= '0;
      for (int i = 0; i < TimerSlots; i++) gen_q[i] <= '0;
      nfired_q    <= '0;
      emit_q      <= '0;
      cnt_q       <= '0;
      v1_q        <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      // the emit state loads or holds the output register itself
      if (out_valid_o && out_ready_i && state_q != StEmit) begin
        out_valid_o <= 1'b0;
      end
      if (scan_start) begin
        cnt_q <= '0;
        v1_q  <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            kind_q   <= kind_i;
            now_q    <= now_us_i;
            dl_q     <= deadline_us_i;
            per_q    <= interval_us_i;
            free_q   <= free_idx;
            picked_q <= '0;
            nfired_q <= '0;
            emit_q   <= '0;
            rslot_q  <= '0;
            rgen_q   <= '0;
            rchg_q   <= 1'b0;
            state_q  <= StScan;
            case (kind_i)
              KindAdd: begin
                mode_q  <= any_free ? ModePreAdd : ModeFinal;
                rstat_q <= any_free ? StatOk : StatFull;
              end
              KindCancel: begin
                mode_q  <= ModeFinal;
                rstat_q <= cancel_hit ? StatOk : StatMiss;
                if (cancel_hit) begin
                  armed_q[hs_w[SW-1:0]] <= 1'b0;
                  gen_q[hs_w[SW-1:0]]   <= gen_q[hs_w[SW-1:0]] + 1'b1;
                end
              end
              KindTick: begin
                mode_q  <= ModeTick;
                rstat_q <= StatOk;
              end
              default: begin
                mode_q  <= ModeFinal;
                rstat_q <= StatOk;
              end
            endcase
          end
        end
        StScan: begin
          if (!scan_start) begin
            if (cnt_q < CW'(TimerSlots)) begin
              cnt_q <= cnt_q + 1'b1;
              v1_q  <= 1'b1;
              s1_q  <= cnt_q[SW-1:0];
            end else begin
              v1_q <= 1'b0;
            end
          end
          if (scan_done) begin
            case (mode_q)
              ModePreAdd: begin
                rchg_q  <= !found || (dl_q < best_dl);
                state_q <= StAddw;
              end
              ModeTick: begin
                if (found) begin
                  lslot_q[nfired_q[LW-1:0]] <= best_slot;
                  lgen_q[nfired_q[LW-1:0]]  <= 8'(gen_q[best_slot]);
                  state_q <= StTupd;
                end else begin
                  if (nfired_q == '0) rstat_q <= StatNotDue;
                  mode_q <= ModeFinal;
                end
              end
              default: state_q <= StFin;
            endcase
          end
        end
        StTupd: begin
          // period data of the picked slot is on the ram output now
          picked_q[best_slot] <= 1'b1;
          if (per_rdata == '0) begin
            armed_q[best_slot] <= 1'b0;
            gen_q[best_slot]   <= gen_q[best_slot] + 1'b1;
          end
          nfired_q <= nfired_q + 1'b1;
          state_q  <= StScan;
          mode_q   <= (nfired_q + 1'b1 == FW'(MaxResults)) ? ModeFinal : ModeTick;
        end
        StAddw: begin
          armed_q[free_q] <= 1'b1;
          rslot_q <= 4'(free_q);
          rgen_q  <= 8'(gen_q[free_q]);
          state_q <= StScan;
          mode_q  <= ModeFinal;
        end
        StFin: begin
          rhas_q   <= found;
          rnext_q  <= found ? best_dl : '0;
          rdelay_q <= !found ? '0 :
                      (diff < TimeW'(min_q)) ? TimeW'(min_q) : diff;
          state_q  <= StEmit;
        end
        StEmit: begin
          // one result beat per cycle once the output register is free
          if (!out_valid_o || out_ready_i) begin
            out_valid_o        <= 1'b1;
            has_deadline_o     <= rhas_q;
            next_deadline_us_o <= rnext_q;
            arm_delay_us_o     <= rdelay_q;
            head_moved_o       <= rchg_q;
            last_o             <= (emit_q + 1'b1 == n_res);
            if (kind_q == KindTick && nfired_q != '0) begin
              status_o     <= StatOk;
              slot_o       <= 4'(lslot_q[emit_q[LW-1:0]]);
              generation_o <= lgen_q[emit_q[LW-1:0]];
              fired_o      <= 1'b1;
            end else begin
              status_o     <= rstat_q;
              slot_o       <= rslot_q;
              generation_o <= rgen_q;
              fired_o      <= 1'b0;
            end
            emit_q <= emit_q + 1'b1;
            if (emit_q + 1'b1 == n_res) begin
              state_q <= StIdle;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule

FILE: sv/tmq_ram.sv
// tmq_ram: generic single write port, single read port ram, registered read
// no dependencies
module tmq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

FILE: sv/tmq_min_unit.sv
// tmq_min_unit: shared compare unit, keeps the earliest candidate of a scan
// uses tmq_pkg
module tmq_min_unit import tmq_pkg::*; #(
  parameter int unsigned SlotW = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             clear_i,
  input  logic             cand_valid_i,
  input  logic [TimeW-1:0] cand_dl_i,
  input  logic [SlotW-1:0] cand_slot_i,
  output logic             found_o,
  output logic [TimeW-1:0] best_dl_o,
  output logic [SlotW-1:0] best_slot_o
);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_o <= 1'b0;
    end else if (clear_i) begin
      found_o <= 1'b0;
    end else if (cand_valid_i && (!found_o || cand_dl_i < best_dl_o)) begin
      found_o <= 1'b1;
    end
  end

  // strict compare in ascending slot order keeps the lowest slot on ties
  always_ff @(posedge clk_i) begin
    if (!clear_i && cand_valid_i && (!found_o || cand_dl_i < best_dl_o)) begin
      best_dl_o   <= cand_dl_i;
      best_slot_o <= cand_slot_i;
    end
  end
endmodule

FILE: test/timer_queue_manager_top_tb.sv
// timer_queue_manager_top_tb: self-checking bench for the ordered timer queue
// predicts add, cancel, tick and unused-kind beats in a class and checks every output beat
// depends on tmq_pkg and timer_queue_manager_top
`timescale 1ns / 1ps

module timer_queue_manager_top_tb;
  import tmq_pkg::*;

  localparam int Slots = 16;

  typedef struct packed {
    logic [1:0]       status;
    logic [3:0]       slot;
    logic [7:0]       generation;
    logic             fired;
    logic             head_moved;
    logic             has_deadline;
    logic [TimeW-1:0] next_deadline;
    logic [TimeW-1:0] arm_delay;
    logic             last;
  } tmr_result_t;

  // timer table model and queue of predicted beats
  class timer_table_sb;
    bit               armed[Slots];
    bit [TimeW-1:0]   due_at[Slots];
    bit [PeriodW-1:0] period[Slots];
    bit [7:0]         gen[Slots];
    bit [DelayW-1:0]  min_delay;
    tmr_result_t      pending[$];
    int               errors;

    function new();
      min_delay = MinDelayRst;
      errors = 0;
      for (int i = 0; i < Slots; i++) begin
        armed[i] = 0;
        gen[i] = 0;
      end
    endfunction

    function bit find_earliest(output bit [TimeW-1:0] t);
      bit any;
      any = 0;
      t = '0;
      for (int i = 0; i < Slots; i++)
        if (armed[i] && (!any || due_at[i] < t)) begin
          t = due_at[i];
          any = 1;
        end
      return any;
    endfunction

    // record one accepted input beat and queue its results
    function void note_item(bit [1:0] kind, bit [TimeW-1:0] now, bit [TimeW-1:0] dl,
                            bit [PeriodW-1:0] per, bit [3:0] hs, bit [7:0] hg);
      tmr_result_t    r[$];
      tmr_result_t    b;
      bit [TimeW-1:0] cur, nxt, dly;
      bit             any, picked[Slots];
      int             fs, best;
      logic [TimeW:0] sum;
      b = '0;
      if (kind == KindAdd) begin
        fs = -1;
        for (int i = Slots - 1; i >= 0; i--) if (!armed[i]) fs = i;
        if (fs < 0) b.status = StatFull;
        else begin
          any = find_earliest(cur);
          b.head_moved = !any || dl < cur;
          armed[fs] = 1;
          due_at[fs] = dl;
          period[fs] = per;
          b.slot = 4'(fs);
          b.generation = gen[fs];
        end
        r.push_back(b);
      end else if (kind == KindCancel) begin
        if (armed[hs] && gen[hs] == hg) begin
          armed[hs] = 0;
          gen[hs]++;
        end else b.status = StatMiss;
        r.push_back(b);
      end else if (kind == KindTick) begin
        for (int i = 0; i < Slots; i++) picked[i] = 0;
        forever begin
          best = -1;
          for (int i = 0; i < Slots; i++)
            if (armed[i] && !picked[i] && due_at[i] <= now &&
                (best < 0 || due_at[i] < due_at[best])) best = i;
          if (best < 0) break;
          picked[best] = 1;
          b = '0;
          b.slot = 4'(best);
          b.generation = gen[best];
          b.fired = 1;
          r.push_back(b);
        end
        foreach (r[k]) begin
          best = int'(r[k].slot);
          if (period[best] != 0) begin
            sum = now + period[best];
            due_at[best] = sum > TimeMax ? TimeMax : sum[TimeW-1:0];
          end else begin
            armed[best] = 0;
            gen[best]++;
          end
        end
        if (r.size() == 0) begin
          b = '0;
          b.status = StatNotDue;
          r.push_back(b);
        end
      end else r.push_back(b);
      // deadline fields reflect the state after the whole item
      any = find_earliest(nxt);
      dly = '0;
      if (any) begin
        dly = nxt > now ? nxt - now : '0;
        if (dly < TimeW'(min_delay)) dly = TimeW'(min_delay);
      end
      foreach (r[k]) begin
        r[k].has_deadline = any;
        r[k].next_deadline = nxt;
        r[k].arm_delay = dly;
        r[k].last = (k == r.size() - 1);
        pending.push_back(r[k]);
      end
    endfunction

    function void check_result(tmr_result_t got);
      tmr_result_t e;
      if (pending.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.status !== e.status) begin
        $error("status exp %0d got %0d", e.status, got.status); errors++;
      end
      if (got.slot !== e.slot) begin
        $error("slot exp %0d got %0d", e.slot, got.slot); errors++;
      end
      if (got.generation !== e.generation) begin
        $error("generation exp %0d got %0d", e.generation, got.generation); errors++;
      end
      if (got.fired !== e.fired) begin
        $error("fired exp %0d got %0d", e.fired, got.fired); errors++;
      end
      if (got.head_moved !== e.head_moved) begin
        $error("head_moved exp %0d got %0d", e.head_moved, got.head_moved); errors++;
      end
      if (got.has_deadline !== e.has_deadline) begin
        $error("has_deadline exp %0d got %0d", e.has_deadline, got.has_deadline);
        errors++;
      end
      if (got.next_deadline !== e.next_deadline) begin
        $error("next_deadline_us exp %0d got %0d", e.next_deadline, got.next_deadline);
        errors++;
      end
      if (got.arm_delay !== e.arm_delay) begin
        $error("arm_delay_us exp %0d got %0d", e.arm_delay, got.arm_delay); errors++;
      end
      if (got.last !== e.last) begin
        $error("last exp %0d got %0d", e.last, got.last); errors++;
      end
    endfunction
  endclass

  logic               clk_i = 0;
  logic               rst_ni = 0;
  logic               cfg_we = 0;
  logic [DelayW-1:0]  cfg_val = '0;
  logic               in_valid = 0;
  logic               in_ready;
  logic [1:0]         kind = '0;
  logic [TimeW-1:0]   now_us = '0;
  logic [TimeW-1:0]   deadline_us = '0;
  logic [PeriodW-1:0] interval_us = '0;
  logic [3:0]         h_slot = '0;
  logic [7:0]         h_gen = '0;
  logic               out_valid;
  logic               out_ready = 0;
  tmr_result_t        got;

  timer_table_sb sb = new();
  longint        cycles = 0;
  int            hold_off = 0;  // long receiver stall, counted down per cycle
  bit            rx_pattern = 0;
  logic [TimeW-1:0] clock_now = '0;  // running bench time, mostly increasing

  always #10 clk_i = ~clk_i;

  timer_queue_manager_top dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .min_arm_delay_us_we_i (cfg_we),
    .min_arm_delay_us_i    (cfg_val),
    .in_valid_i            (in_valid),
    .in_ready_o            (in_ready),
    .kind_i                (kind),
    .now_us_i              (now_us),
    .deadline_us_i         (deadline_us),
    .interval_us_i         (interval_us),
    .handle_slot_i         (h_slot),
    .handle_generation_i   (h_gen),
    .out_valid_o           (out_valid),
    .out_ready_i           (out_ready),
    .status_o              (got.status),
    .slot_o                (got.slot),
    .generation_o          (got.generation),
    .fired_o               (got.fired),
    .head_moved_o          (got.head_moved),
    .has_deadline_o        (got.has_deadline),
    .next_deadline_us_o    (got.next_deadline),
    .arm_delay_us_o        (got.arm_delay),
    .last_o                (got.last)
  );

  // timeout guard, far above the slowest legal run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("FAIL");
      $finish;
    end
  end

  // receiver: check accepted beats, stall on its own pattern or a long hold-off
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) sb.check_result(got);
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 0;
    end else if (rx_pattern) out_ready <= ($urandom_range(0, 3) != 0);
    else out_ready <= 1;
  end

  // one input beat; valid held until accepted, then left to the caller
  task automatic send_item(bit [1:0] k, bit [TimeW-1:0] nw, bit [TimeW-1:0] dl,
                           bit [PeriodW-1:0] per, bit [3:0] hs, bit [7:0] hg);
    in_valid <= 1;
    kind <= k;
    now_us <= nw;
    deadline_us <= dl;
    interval_us <= per;
    h_slot <= hs;
    h_gen <= hg;
    do @(posedge clk_i); while (!in_ready);
    sb.note_item(k, nw, dl, per, hs, hg);
  endtask

  // drop valid and let the bench idle for a gap set by n
  task automatic idle_gap(int n);
    in_valid <= 0;
    repeat (n + 1) @(posedge clk_i);
  endtask

  // drain all predicted beats, then allow for work that yields no beat
  task automatic wait_drained();
    in_valid <= 0;
    do @(posedge clk_i); while (sb.pending.size() != 0);
    repeat (120) @(posedge clk_i);
  endtask

  task automatic write_min_delay(bit [DelayW-1:0] v);
    wait_drained();
    cfg_we <= 1;
    cfg_val <= v;
    @(posedge clk_i);
    cfg_we <= 0;
    sb.min_delay = v;
  endtask

  // random item biased toward valid handles and due timers
  task automatic send_random();
    bit [1:0]         k;
    bit [TimeW-1:0]   dl;
    bit [PeriodW-1:0] per;
    bit [3:0]         hs;
    bit [7:0]         hg;
    int               sel;
    sel = $urandom_range(0, 99);
    hs = 4'($urandom_range(0, 15));
    hg = 8'($urandom);
    per = '0;
    clock_now = clock_now + $urandom_range(0, 400);
    dl = clock_now + $urandom_range(0, 800);
    if (sel < 40) begin
      k = KindAdd;
      case ($urandom_range(0, 3))
        0: per = '0;
        1: per = PeriodW'($urandom_range(1, 600));
        2: per = PeriodW'({$urandom, $urandom});
        default: per = PeriodW'($urandom_range(0, 50));
      endcase
      if ($urandom_range(0, 9) == 0) dl = TimeW'({$urandom, $urandom});
    end else if (sel < 60) begin
      k = KindCancel;
      if ($urandom_range(0, 3) != 0) hg = sb.gen[hs];
    end else if (sel < 95) k = KindTick;
    else k = KindUnused;
    send_item(k, clock_now, dl, per, hs, hg);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: fill the table, overflow, cancel hit and miss, ticks
    for (int i = 0; i < Slots; i++)
      send_item(KindAdd, 62'd0, 62'd1000 - i * 10, (i % 2) ? 40'd500 : 40'd0, 0, 0);
    send_item(KindAdd, 62'd0, 62'd5, 40'd0, 0, 0);
    send_item(KindCancel, 62'd0, 0, 0, 4'd3, 8'd0);
    send_item(KindCancel, 62'd0, 0, 0, 4'd3, 8'd0);
    send_item(KindCancel, 62'd0, 0, 0, 4'd4, 8'hff);
    send_item(KindTick, 62'd10, 0, 0, 0, 0);
    send_item(KindUnused, TimeMax, TimeMax, {PeriodW{1'b1}}, 4'hf, 8'hff);
    send_item(KindTick, 62'd2000, 0, 0, 0, 0);
    // saturating re-arm
    send_item(KindAdd, TimeMax - 5, TimeMax - 10, {PeriodW{1'b1}}, 0, 0);
    send_item(KindTick, TimeMax, 0, 0, 0, 0);
    send_item(KindTick, TimeMax, 0, 0, 0, 0);
    write_min_delay(16'hffff);
    send_item(KindTick, 62'd0, 0, 0, 0, 0);
    write_min_delay(16'd0);
    send_item(KindTick, 62'd1, 0, 0, 0, 0);

    // clear the table so random time starts low
    for (int i = 0; i < Slots; i++) send_item(KindCancel, 0, 0, 0, 4'(i), sb.gen[i]);
    wait_drained();

    // pressure: long receiver hold-off while the sender keeps offering
    hold_off = 300;
    rx_pattern = 1;
    for (int i = 0; i < 12; i++) send_random();
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      write_min_delay(ph == 0 ? 16'd50 : ph == 1 ? 16'd0 : ph == 2 ? 16'hffff :
                      16'($urandom));
      rx_pattern = (ph != 3);
      for (int n = 0; n < 11; ) begin
        int burst;
        burst = $urandom_range(1, 6);
        for (int b = 0; b < burst && n < 11; b++, n++) send_random();
        idle_gap($urandom_range(0, 8));
      end
    end

    wait_drained();
    if (sb.errors == 0 && sb.pending.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
